// ===== rtl/core/seven_bit_packet_codec_checksum_macros.svh =====
// Assertion macros for the seven-bit packet codec.
// Used by rtl/core modules that carry concurrent checks; no other dependencies.
`ifndef SEVEN_BIT_PACKET_CODEC_CHECKSUM_MACROS_SVH
`define SEVEN_BIT_PACKET_CODEC_CHECKSUM_MACROS_SVH

// same-cycle implication, disabled during reset
`define SBPC_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("codec assertion failed");

// next-cycle implication, disabled during reset
`define SBPC_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("codec assertion failed");

`endif

// ===== rtl/core/sbpc_pkg.sv =====
// Shared types and constants for the seven-bit packet codec.
// No dependencies; imported by sbpc_data_buf and the top level.
package sbpc_pkg;

   localparam int MAX_DATA_DEF = 7;
   localparam int BYTE_W       = 8;
   localparam int KIND_W       = 2;
   localparam int HDR_IDX_W    = 3;

   localparam logic [BYTE_W-1:0] MARK_BIT  = 8'h80;
   localparam logic [BYTE_W-1:0] LOW7_MASK = 8'h7f;

   localparam logic [KIND_W-1:0] KIND_ID     = 2'd0;
   localparam logic [KIND_W-1:0] KIND_HEADER = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DATA   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CHECK  = 2'd3;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_ID,
      ST_HEADER,
      ST_DATA,
      ST_CHECK,
      ST_DEC_DATA
   } seq_state_type;

endpackage

// ===== rtl/core/seven_bit_packet_codec_checksum.sv =====
// Seven-bit packet codec with checksum, top level.
// Depends on sbpc_pkg, sbpc_data_buf and seven_bit_packet_codec_checksum_macros.svh.
//
// Usage:
//  - req_* is a valid/ready byte stream: byte value plus first/last markers.
//    req_ready is high only while the sequencer is idle; one item at a time.
//  - rsp_* is a valid/ready result stream: byte, kind, check flag, overflow
//    flag and an end-of-run flag on the last result of each item.
//  - csr_write_enable/csr_write_data set the direction (0 encode, 1 decode)
//    and close any open packet; write only while the block is idle.
// Flow:
//  - An item that gives no result or is buffered goes from evaluate to idle.
//  - Any other item is evaluated, then gives one result per cycle while the
//    receiver takes them, from a single shared 8-bit adder that builds the
//    checksum and a buffer with one write port and a registered read port.
//  - The first result is registered in the rsp register after evaluation.
// Reset clears the direction and all packet state; the buffer is not cleared.
// req_ready stays low while reset is high.
// A stalled receiver holds the rsp register; the sequencer waits with it.
module seven_bit_packet_codec_checksum #(
   parameter int MAX_DATA = sbpc_pkg::MAX_DATA_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [sbpc_pkg::BYTE_W-1:0] req_byte_value,
   input  logic                        req_first_byte,
   input  logic                        req_last_byte,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [sbpc_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [sbpc_pkg::KIND_W-1:0] rsp_kind,
   output logic                        rsp_check_ok,
   output logic                        rsp_overflow,
   output logic                        rsp_end_of_run,
   input  logic                        csr_write_enable,
   input  logic                        csr_write_data
);
   import sbpc_pkg::*;

   `include "seven_bit_packet_codec_checksum_macros.svh"

   localparam int CNT_W = $clog2(MAX_DATA + 1);
   localparam int IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;

   seq_state_type state_ff, state_in;

   logic              dir_ff, dir_in;
   logic              in_packet_ff, in_packet_in;
   logic [BYTE_W-1:0] sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [IDX_W-1:0]  idx_ff, idx_in;
   logic [BYTE_W-1:0] header_ff, header_in;
   logic              seen_ff, seen_in;
   logic              ovf_ff, ovf_in;

   logic [BYTE_W-1:0] item_byte_ff, item_byte_in;
   logic              item_first_ff, item_first_in;
   logic              item_last_ff, item_last_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic [KIND_W-1:0] rsp_kind_ff, rsp_kind_in;
   logic              rsp_ok_ff, rsp_ok_in;
   logic              rsp_ovf_ff, rsp_ovf_in;
   logic              rsp_eor_ff, rsp_eor_in;

   logic              slot_free;
   logic              emit;
   logic [BYTE_W-1:0] add_op;
   logic [BYTE_W-1:0] add_sum;
   logic              buf_we;
   logic              buf_re;
   logic [IDX_W-1:0]  buf_raddr;
   logic [BYTE_W-1:0] buf_rdata;
   logic              room;
   logic              last_data;
   logic [CNT_W-1:0]  idx_next;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign room      = count_ff < CNT_W'(MAX_DATA);
   assign idx_next  = CNT_W'(idx_ff) + CNT_W'(1);
   assign last_data = idx_next == count_ff;
   assign add_sum   = sum_ff + add_op;

   sbpc_data_buf #(
      .MAX_DATA (MAX_DATA),
      .IDX_W    (IDX_W)
   ) u_buf (
      .clock   (clock),
      .wr_en   (buf_we),
      .wr_addr (IDX_W'(count_ff)),
      .wr_data (item_byte_ff),
      .rd_en   (buf_re),
      .rd_addr (buf_raddr),
      .rd_data (buf_rdata)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         dir_ff       <= 1'b0;
         in_packet_ff <= 1'b0;
         sum_ff       <= '0;
         count_ff     <= '0;
         idx_ff       <= '0;
         header_ff    <= '0;
         seen_ff      <= 1'b0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         dir_ff       <= dir_in;
         in_packet_ff <= in_packet_in;
         sum_ff       <= sum_in;
         count_ff     <= count_in;
         idx_ff       <= idx_in;
         header_ff    <= header_in;
         seen_ff      <= seen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_byte_ff  <= item_byte_in;
      item_first_ff <= item_first_in;
      item_last_ff  <= item_last_in;
      rsp_byte_ff   <= rsp_byte_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_ok_ff     <= rsp_ok_in;
      rsp_ovf_ff    <= rsp_ovf_in;
      rsp_eor_ff    <= rsp_eor_in;
   end

   always_comb begin
      state_in      = state_ff;
      dir_in        = dir_ff;
      in_packet_in  = in_packet_ff;
      sum_in        = sum_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      header_in     = header_ff;
      seen_in       = seen_ff;
      ovf_in        = ovf_ff;
      item_byte_in  = item_byte_ff;
      item_first_in = item_first_ff;
      item_last_in  = item_last_ff;
      req_ready     = 1'b0;
      emit          = 1'b0;
      add_op        = item_byte_ff;
      buf_we        = 1'b0;
      buf_re        = 1'b0;
      buf_raddr     = '0;
      rsp_byte_in   = rsp_byte_ff;
      rsp_kind_in   = rsp_kind_ff;
      rsp_ok_in     = rsp_ok_ff;
      rsp_ovf_in    = rsp_ovf_ff;
      rsp_eor_in    = rsp_eor_ff;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (csr_write_enable) begin
               dir_in       = csr_write_data;
               in_packet_in = 1'b0;
            end
            if (req_valid) begin
               item_byte_in  = req_byte_value;
               item_first_in = req_first_byte;
               item_last_in  = req_last_byte;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (item_first_ff) begin
               in_packet_in = 1'b1;
               sum_in       = item_byte_ff;
               count_in     = '0;
               header_in    = '0;
               seen_in      = 1'b0;
               ovf_in       = 1'b0;
               state_in     = ST_ID;
            end else if (!in_packet_ff) begin
               state_in = ST_IDLE;
            end else if (!dir_ff) begin
               if (room) begin
                  buf_we                       = 1'b1;
                  header_in[HDR_IDX_W'(count_ff)] = item_byte_ff[BYTE_W-1];
                  count_in                     = count_ff + CNT_W'(1);
               end else begin
                  ovf_in = 1'b1;
               end
               state_in = item_last_ff ? ST_HEADER : ST_IDLE;
            end else if (item_last_ff) begin
               state_in = ST_CHECK;
            end else begin
               sum_in   = add_sum;
               state_in = ST_IDLE;
               if (!seen_ff) begin
                  header_in = item_byte_ff;
                  seen_in   = 1'b1;
               end else if (room) begin
                  state_in = ST_DEC_DATA;
               end else begin
                  ovf_in = 1'b1;
               end
            end
         end
         ST_ID: begin
            if (slot_free) begin
               emit        = 1'b1;
               rsp_byte_in = item_byte_ff;
               rsp_kind_in = KIND_ID;
               rsp_ok_in   = !dir_ff;
               rsp_ovf_in  = ovf_ff;
               rsp_eor_in  = !item_last_ff;
               if (!item_last_ff) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in = dir_ff ? ST_CHECK : ST_HEADER;
               end
            end
         end
         ST_HEADER: begin
            add_op = header_ff | MARK_BIT;
            if (slot_free) begin
               emit        = 1'b1;
               rsp_byte_in = add_op;
               rsp_kind_in = KIND_HEADER;
               rsp_ok_in   = 1'b1;
               rsp_ovf_in  = ovf_ff;
               rsp_eor_in  = 1'b0;
               sum_in      = add_sum;
               idx_in      = '0;
               buf_re      = 1'b1;
               buf_raddr   = '0;
               state_in    = (count_ff == '0) ? ST_CHECK : ST_DATA;
            end
         end
         ST_DATA: begin
            add_op = buf_rdata | MARK_BIT;
            if (slot_free) begin
               emit        = 1'b1;
               rsp_byte_in = add_op;
               rsp_kind_in = KIND_DATA;
               rsp_ok_in   = 1'b1;
               rsp_ovf_in  = ovf_ff;
               rsp_eor_in  = 1'b0;
               sum_in      = add_sum;
               idx_in      = IDX_W'(idx_next);
               buf_re      = !last_data;
               buf_raddr   = IDX_W'(idx_next);
               state_in    = last_data ? ST_CHECK : ST_DATA;
            end
         end
         ST_CHECK: begin
            if (slot_free) begin
               emit         = 1'b1;
               rsp_kind_in  = KIND_CHECK;
               rsp_ovf_in   = ovf_ff;
               rsp_eor_in   = 1'b1;
               in_packet_in = 1'b0;
               state_in     = ST_IDLE;
               if (dir_ff) begin
                  rsp_byte_in = item_byte_ff;
                  rsp_ok_in   = !item_first_ff &&
                                ((sum_ff & LOW7_MASK) == (item_byte_ff & LOW7_MASK));
               end else begin
                  rsp_byte_in = sum_ff | MARK_BIT;
                  rsp_ok_in   = 1'b1;
               end
            end
         end
         ST_DEC_DATA: begin
            if (slot_free) begin
               emit        = 1'b1;
               rsp_byte_in = (item_byte_ff & LOW7_MASK) |
                             (header_ff[HDR_IDX_W'(count_ff)] ? MARK_BIT : '0);
               rsp_kind_in = KIND_DATA;
               rsp_ok_in   = 1'b0;
               rsp_ovf_in  = ovf_ff;
               rsp_eor_in  = 1'b1;
               count_in    = count_ff + CNT_W'(1);
               state_in    = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_byte   = rsp_byte_ff;
   assign rsp_kind       = rsp_kind_ff;
   assign rsp_check_ok   = rsp_ok_ff;
   assign rsp_overflow   = rsp_ovf_ff;
   assign rsp_end_of_run = rsp_eor_ff;

   `SBPC_ASSERT_IMP(a_data_idx_in_range, clock, reset,
      state_ff == ST_DATA, CNT_W'(idx_ff) < count_ff && !dir_ff)
   `SBPC_ASSERT_IMP(a_dec_data_room, clock, reset,
      state_ff == ST_DEC_DATA, dir_ff && room && in_packet_ff)
   `SBPC_ASSERT_NXT(a_check_closes_packet, clock, reset,
      state_ff == ST_CHECK && slot_free, !in_packet_ff && rsp_valid && rsp_end_of_run)
   `SBPC_ASSERT_IMP(a_count_bounded, clock, reset,
      in_packet_ff, count_ff <= CNT_W'(MAX_DATA))

endmodule

// ===== rtl/core/sbpc_data_buf.sv =====
// Data byte buffer of the packet codec: one write port, one registered read port.
// Depends on sbpc_pkg.
module sbpc_data_buf #(
   parameter int MAX_DATA = sbpc_pkg::MAX_DATA_DEF,
   parameter int IDX_W    = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1
) (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [IDX_W-1:0]            wr_addr,
   input  logic [sbpc_pkg::BYTE_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [IDX_W-1:0]            rd_addr,
   output logic [sbpc_pkg::BYTE_W-1:0] rd_data
);
   import sbpc_pkg::*;

   logic [BYTE_W-1:0] mem [MAX_DATA];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
